// File: rtl/ptl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_pkg
// shared types, register indexes and reset values of the pedestrian light
// ----------------------------------------------------------------------------
package ptl_pkg;

	localparam int TIME_W = 16;
	localparam int SLOT_W = 10;
	localparam int CAD_W  = 4;
	localparam int PH_W   = 3;
	localparam int IDX_W  = 3;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_RED_TIME      = 3'd0;
	localparam logic [IDX_W-1:0] CFG_YELLOW_TIME   = 3'd1;
	localparam logic [IDX_W-1:0] CFG_WALK_DELAY    = 3'd2;
	localparam logic [IDX_W-1:0] CFG_SLOT_LENGTH   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd4;
	localparam logic [IDX_W-1:0] CFG_BEEP_SLOTS    = 3'd5;
	localparam logic [IDX_W-1:0] CFG_QUIET_SLOTS   = 3'd6;

	// light phases
	localparam logic [PH_W-1:0] PH_RED        = 3'd0;
	localparam logic [PH_W-1:0] PH_RED_YELLOW = 3'd1;
	localparam logic [PH_W-1:0] PH_YELLOW     = 3'd2;
	localparam logic [PH_W-1:0] PH_GREEN      = 3'd3;
	localparam logic [PH_W-1:0] PH_GREEN_REQ  = 3'd4;

	localparam logic [TIME_W-1:0] RST_RED_TIME      = 16'd10000;
	localparam logic [TIME_W-1:0] RST_YELLOW_TIME   = 16'd2000;
	localparam logic [TIME_W-1:0] RST_WALK_DELAY    = 16'd5000;
	localparam logic [SLOT_W-1:0] RST_SLOT_LENGTH   = 10'd250;
	localparam logic [SLOT_W-1:0] RST_SAMPLE_PERIOD = 10'd50;
	localparam logic [CAD_W-1:0]  RST_BEEP_SLOTS    = 4'd6;
	localparam logic [CAD_W-1:0]  RST_QUIET_SLOTS   = 4'd2;

	typedef struct packed {
		logic [TIME_W-1:0] red_time_ms;
		logic [TIME_W-1:0] yellow_time_ms;
		logic [TIME_W-1:0] walk_delay_ms;
		logic [SLOT_W-1:0] slot_length_ms;
		logic [SLOT_W-1:0] sample_period_ms;
		logic [CAD_W-1:0]  beep_slots;
		logic [CAD_W-1:0]  quiet_slots;
	} cfg_t;

	typedef struct packed {
		logic            red_lamp;
		logic            yellow_lamp;
		logic            green_lamp;
		logic            buzzer_drive;
		logic [PH_W-1:0] light_phase;
	} res_t;

	// zero length or period counts as one
	function automatic logic [SLOT_W-1:0] at_least_one(input logic [SLOT_W-1:0] v);
		return (v == '0) ? SLOT_W'(1) : v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ptl_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_cfg_regs
// configuration register file, write only, out of range indexes ignored
// ----------------------------------------------------------------------------
module ptl_cfg_regs import ptl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [TIME_W-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_time_ms      <= RST_RED_TIME;
			cfg_q.yellow_time_ms   <= RST_YELLOW_TIME;
			cfg_q.walk_delay_ms    <= RST_WALK_DELAY;
			cfg_q.slot_length_ms   <= RST_SLOT_LENGTH;
			cfg_q.sample_period_ms <= RST_SAMPLE_PERIOD;
			cfg_q.beep_slots       <= RST_BEEP_SLOTS;
			cfg_q.quiet_slots      <= RST_QUIET_SLOTS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RED_TIME:      cfg_q.red_time_ms      <= cfg_data;
				CFG_YELLOW_TIME:   cfg_q.yellow_time_ms   <= cfg_data;
				CFG_WALK_DELAY:    cfg_q.walk_delay_ms    <= cfg_data;
				CFG_SLOT_LENGTH:   cfg_q.slot_length_ms   <= cfg_data[SLOT_W-1:0];
				CFG_SAMPLE_PERIOD: cfg_q.sample_period_ms <= cfg_data[SLOT_W-1:0];
				CFG_BEEP_SLOTS:    cfg_q.beep_slots       <= cfg_data[CAD_W-1:0];
				CFG_QUIET_SLOTS:   cfg_q.quiet_slots      <= cfg_data[CAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/ptl_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_mod_unit
// restoring remainder, one bit a cycle, re-aligns the sample phase counter
// with the slot position after the sample period changes
// ----------------------------------------------------------------------------
module ptl_mod_unit import ptl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SLOT_W-1:0] dividend,
	input  wire logic [SLOT_W-1:0] divisor,
	output logic                   busy,
	output logic                   done,
	output logic [SLOT_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(SLOT_W);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] dvd_q;
	logic [SLOT_W-1:0] dvs_q;
	logic [SLOT_W-1:0] rem_q;
	logic              done_q;
	logic [SLOT_W:0]   shifted;
	logic [SLOT_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, dvd_q[SLOT_W-1]};
		rem_next = (shifted >= {1'b0, dvs_q}) ? SLOT_W'(shifted - {1'b0, dvs_q})
		                                      : shifted[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SLOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SLOT_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	// the load cycle counts as busy so no tick overwrites the loaded phase
	assign busy      = busy_q || done_q || start;
	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// File: rtl/ptl_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_core
// per-tick update of phase, timers, slot position, cadence and request
// ----------------------------------------------------------------------------
module ptl_core import ptl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire logic              button_level,
	input  wire cfg_t              cfg,
	input  wire logic              smp_load,
	input  wire logic [SLOT_W-1:0] smp_value,
	output logic [SLOT_W-1:0]      slot_pos,
	output res_t                   res
);

	logic [PH_W-1:0]   phase_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [SLOT_W-1:0] pos_q;
	logic [SLOT_W-1:0] smp_q;   // pos_q modulo the sample period
	logic              snd_q;
	logic [CAD_W-1:0]  cad_q;
	logic              req_q;

	logic [PH_W-1:0]   phase_d;
	logic [TIME_W-1:0] elapsed_d;
	logic [SLOT_W-1:0] pos_d;
	logic [SLOT_W-1:0] smp_d;
	logic              snd_d;
	logic [CAD_W-1:0]  cad_d;
	logic              req_d;

	logic [SLOT_W-1:0] slen;
	logic [SLOT_W-1:0] sper;
	logic [SLOT_W-1:0] pos0;
	logic [SLOT_W-1:0] smp0;
	logic [SLOT_W:0]   pos_inc;
	logic [SLOT_W:0]   smp_inc;
	logic [TIME_W-1:0] el1;
	logic              green;
	logic              slotted;
	logic              slot_end;
	logic              do_enter;
	logic [PH_W-1:0]   enter_ph;

	always_comb begin
		slen    = at_least_one(cfg.slot_length_ms);
		sper    = at_least_one(cfg.sample_period_ms);
		green   = (phase_q == PH_GREEN) || (phase_q == PH_GREEN_REQ);
		slotted = green || (phase_q == PH_RED);

		// slot restarts if it was shortened to or below the current position
		pos0 = (pos_q >= slen) ? '0 : pos_q;
		smp0 = (pos_q >= slen) ? '0 : smp_q;

		snd_d = snd_q;
		cad_d = cad_q;
		if (slotted && pos0 == '0) begin
			if (green) begin
				cad_d = cad_q + CAD_W'(1);
				if (snd_q && cad_d == cfg.beep_slots) begin
					snd_d = 1'b0;
					cad_d = '0;
				end else if (!snd_q && cad_d == cfg.quiet_slots) begin
					snd_d = 1'b1;
					cad_d = '0;
				end
			end else begin
				snd_d = !snd_q;
			end
		end

		req_d = req_q || (green && button_level && smp0 == '0);

		res.red_lamp     = (phase_q == PH_RED) || (phase_q == PH_RED_YELLOW);
		res.yellow_lamp  = (phase_q == PH_RED_YELLOW) || (phase_q == PH_YELLOW);
		res.green_lamp   = green;
		res.buzzer_drive = slotted && snd_d && !pos0[0];
		res.light_phase  = phase_q;

		el1 = (elapsed_q == '1) ? elapsed_q : elapsed_q + TIME_W'(1);

		pos_inc  = {1'b0, pos0} + (SLOT_W+1)'(1);
		smp_inc  = {1'b0, smp0} + (SLOT_W+1)'(1);
		slot_end = pos_inc >= {1'b0, slen};

		do_enter = 1'b0;
		enter_ph = phase_q;
		if (slotted) begin
			pos_d = slot_end ? '0 : pos_inc[SLOT_W-1:0];
			smp_d = (slot_end || smp_inc == {1'b0, sper}) ? '0 : smp_inc[SLOT_W-1:0];
			if (slot_end) begin
				if (phase_q == PH_GREEN) begin
					do_enter = req_d;
					enter_ph = PH_GREEN_REQ;
				end else if (phase_q == PH_GREEN_REQ) begin
					do_enter = el1 >= cfg.walk_delay_ms;
					enter_ph = PH_YELLOW;
				end else begin
					do_enter = el1 >= cfg.red_time_ms;
					enter_ph = PH_RED_YELLOW;
				end
			end
		end else begin
			pos_d    = '0;
			smp_d    = '0;
			do_enter = el1 >= cfg.yellow_time_ms;
			enter_ph = (phase_q == PH_YELLOW) ? PH_RED : PH_GREEN;
		end

		phase_d   = phase_q;
		elapsed_d = el1;
		if (do_enter) begin
			phase_d   = enter_ph;
			elapsed_d = '0;
			if (enter_ph == PH_YELLOW)
				req_d = 1'b0;
			if (enter_ph == PH_RED_YELLOW)
				snd_d = 1'b0;
			if (enter_ph == PH_GREEN) begin
				snd_d = 1'b1;
				cad_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_GREEN;
			elapsed_q <= '0;
			pos_q     <= '0;
			smp_q     <= '0;
			snd_q     <= 1'b1;
			cad_q     <= '0;
			req_q     <= 1'b0;
		end else if (tick) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			pos_q     <= pos_d;
			smp_q     <= smp_d;
			snd_q     <= snd_d;
			cad_q     <= cad_d;
			req_q     <= req_d;
		end else if (smp_load) begin
			smp_q <= smp_value;
		end
	end

	assign slot_pos = pos_q;

endmodule
`default_nettype wire

// File: rtl/ptl_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_out_skid
// result register with one skid entry, ready is a registered signal
// ----------------------------------------------------------------------------
module ptl_out_skid import ptl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_word,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_word
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				main_valid_q <= push;
		end else if (push) begin
			if (main_valid_q)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q)
			main_q <= skid_q;
		else if (push && (pop || !main_valid_q))
			main_q <= push_word;
		if (push && main_valid_q && !pop)
			skid_q <= push_word;
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;

	// skid entry only fills behind a waiting result
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry valid without main entry");

	// no word is pushed into a full buffer
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("push while skid entry occupied");

	// draining the last word with nothing arriving empties the buffer
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !skid_valid_q && !push) |=> !main_valid_q)
		else $error("buffer not empty after last word left");

endmodule
`default_nettype wire

// File: rtl/pedestrian_traffic_light.sv
`timescale 1ns / 1ps
`default_nettype none
// a result word is written into the output buffer when its tick word is accepted
// throughput: one word per cycle while in_stall is low; a two-entry output buffer
// keeps input open while one result waits
// a write to the sample period stalls the input while a bit-serial remainder
// unit realigns the sample counter
// reset: asynchronous, active low; registers return to reset values, phase green
// ----------------------------------------------------------------------------
// pedestrian_traffic_light
// millisecond-tick pedestrian crossing light with buzzer cadence
// ----------------------------------------------------------------------------
module pedestrian_traffic_light import ptl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [TIME_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              button_level,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   red_lamp,
	output logic                   yellow_lamp,
	output logic                   green_lamp,
	output logic                   buzzer_drive,
	output logic [PH_W-1:0]        light_phase
);

	cfg_t              cfg;
	res_t              res;
	res_t              out_word;
	logic              tick;
	logic              full;
	logic              mod_start;
	logic              mod_busy;
	logic              mod_done;
	logic [SLOT_W-1:0] mod_rem;
	logic [SLOT_W-1:0] slot_pos;

	assign in_stall  = full || mod_busy;
	assign tick      = in_valid && !in_stall;
	assign mod_start = cfg_wr_en && (cfg_index == CFG_SAMPLE_PERIOD);

	ptl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptl_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (slot_pos),
		.divisor   (at_least_one(cfg_data[SLOT_W-1:0])),
		.busy      (mod_busy),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	ptl_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.button_level (button_level),
		.cfg          (cfg),
		.smp_load     (mod_done),
		.smp_value    (mod_rem),
		.slot_pos     (slot_pos),
		.res          (res)
	);

	ptl_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tick),
		.push_word (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign red_lamp     = out_word.red_lamp;
	assign yellow_lamp  = out_word.yellow_lamp;
	assign green_lamp   = out_word.green_lamp;
	assign buzzer_drive = out_word.buzzer_drive;
	assign light_phase  = out_word.light_phase;

endmodule
`default_nettype wire
